@@ sv/sgw_pkg.sv @@
// Shared types, codes and small tables of the scaled glyph row pixel writer.
package sgw_pkg;

    // Pixel formats held in the pixel_mode register.
    localparam logic [1:0] MODE_BGRA32 = 2'd0;
    localparam logic [1:0] MODE_BGR24  = 2'd1;
    localparam logic [1:0] MODE_RGB565 = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_FRAME_BASE    = 3'd0;
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd1;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd2;
    localparam logic [2:0] REG_LINE_PITCH    = 3'd3;
    localparam logic [2:0] REG_PIXEL_MODE    = 3'd4;

    // One glyph row to draw.
    typedef struct packed {
        logic [7:0]  glyph_row;
        logic [2:0]  row_index;
        logic [11:0] origin_x;
        logic [11:0] origin_y;
        logic [23:0] fore_rgb;
        logic [23:0] back_rgb;
    } in_t;

    // One framebuffer write.
    typedef struct packed {
        logic [31:0] byte_address;
        logic [31:0] pixel_data;
        logic [2:0]  byte_count;
        logic        last_write;
    } out_t;

    // Position of the sweep inside the scaled row.
    typedef struct packed {
        logic [2:0] dx;
        logic       sy;
        logic       sx;
    } cursor_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW0,
        ST_ROW1,
        ST_SWEEP,
        ST_FLUSH
    } state_t;

    // Left edge of a glyph column inside the 12 pixel wide cell.
    function automatic logic [3:0] col_offset(input logic [2:0] dx);
        return (4'(dx[2:1]) * 4'd3) + 4'({dx[0], 1'b0});
    endfunction

    // Top edge of a glyph row inside the 14 line high cell.
    function automatic logic [3:0] row_offset(input logic [2:0] row);
        return (row[2] ? 4'd7 : 4'd0) + 4'({row[1:0], 1'b0});
    endfunction

    // Colour 0xRRGGBB packed down to RGB565.
    function automatic logic [15:0] to_rgb565(input logic [23:0] c);
        return {c[23:19], c[15:10], c[7:3]};
    endfunction

    // Bytes stored per pixel; the unsupported mode gives zero.
    function automatic logic [2:0] mode_bytes(input logic [1:0] mode);
        logic [2:0] b;
        unique case (mode)
            MODE_BGRA32: b = 3'd4;
            MODE_BGR24:  b = 3'd3;
            MODE_RGB565: b = 3'd2;
            default:     b = 3'd0;
        endcase
        return b;
    endfunction

endpackage

@@ sv/sgw_pixel_gen.sv @@
// Evaluates the candidate pixel at the sweep cursor: clipping, address and data.
module sgw_pixel_gen (
    input  sgw_pkg::in_t     item,
    input  logic [12:0]      y0,
    input  sgw_pkg::cursor_t cur,
    input  logic [1:0]       pixel_mode,
    input  logic [12:0]      screen_width,
    input  logic [12:0]      screen_height,
    input  logic [31:0]      row_addr0,
    input  logic [31:0]      row_addr1,
    output logic             visible,
    output sgw_pkg::out_t    cand
);

    logic [12:0] x_cur;
    logic [12:0] y_cur;
    logic [14:0] x_bytes;
    logic [23:0] color;
    logic [31:0] row_addr;

    // Pixel coordinates and clipping against the visible screen.
    assign x_cur   = 13'(item.origin_x) + 13'(sgw_pkg::col_offset(cur.dx)) + 13'(cur.sx);
    assign y_cur   = y0 + 13'(cur.sy);
    assign visible = (x_cur < screen_width) && (y_cur < screen_height);

    // Byte offset of the pixel within its line.
    always_comb begin
        unique case (pixel_mode)
            sgw_pkg::MODE_BGRA32: x_bytes = {x_cur, 2'b00};
            sgw_pkg::MODE_BGR24:  x_bytes = 15'({x_cur, 1'b0}) + 15'(x_cur);
            sgw_pkg::MODE_RGB565: x_bytes = 15'({x_cur, 1'b0});
            default:              x_bytes = '0;
        endcase
    end

    assign row_addr = cur.sy ? row_addr1 : row_addr0;
    assign color    = item.glyph_row[3'd7 - cur.dx] ? item.fore_rgb : item.back_rgb;

    // The write itself; the last flag is set later by the sequencer.
    always_comb begin
        cand.byte_address = row_addr + 32'(x_bytes);
        cand.pixel_data   = (pixel_mode == sgw_pkg::MODE_RGB565)
                            ? {16'h0000, sgw_pkg::to_rgb565(color)}
                            : {8'h00, color};
        cand.byte_count   = sgw_pkg::mode_bytes(pixel_mode);
        cand.last_write   = 1'b0;
    end

endmodule

@@ sv/scaled_glyph_row_pixel_writer.sv @@
// Top level of the scaled glyph row pixel writer: sequencer, registers and output stage.
//
// An item on the s_ channel is one 8-pixel glyph row with its row index, the
// character cell origin and two colours. The block draws it scaled by 3/2 across
// and 7/4 down and emits one framebuffer write per visible pixel on the m_
// channel, ordered by glyph column, then sub-row, then sub-column; the final
// write of an item carries last_write. Clipped pixels and pixel mode 3 give no
// writes. Configuration registers are written through cfg_wr_en, cfg_index and
// cfg_wdata; the user must write them only while the block is idle, which the
// block itself does not enforce. Unknown indexes are ignored. After an item is
// accepted, the shared multiplier forms the two line start addresses in ST_ROW0
// and ST_ROW1, then the sweep visits one candidate pixel a cycle unless stalled:
// 12 candidates for a one-line row, 24 for a two-line row, plus the flush state
// that releases the final write. One write is held back until the next visible
// one is found, so the last flag is known; the first write moves out at the second
// visible pixel or in the flush state. A receiver stall halts the sweep only when
// both the held write and the output register are full. Reset (aresetn low,
// sampled on aclk) empties both, returns to idle and restores register defaults.
module scaled_glyph_row_pixel_writer (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_wdata,
    input  logic          s_valid,
    output logic          s_ready,
    input  sgw_pkg::in_t  s_item,
    output logic          m_valid,
    input  logic          m_ready,
    output sgw_pkg::out_t m_item
);

    // Configuration registers.
    logic [31:0] frame_base_reg;
    logic [12:0] screen_width_reg;
    logic [12:0] screen_height_reg;
    logic [14:0] line_pitch_reg;
    logic [1:0]  pixel_mode_reg;

    // Sequencer and item registers.
    sgw_pkg::state_t  state_reg, state_next;
    sgw_pkg::in_t     item_reg, item_next;
    logic [12:0]      y0_reg, y0_next;
    logic             tall_reg, tall_next;
    sgw_pkg::cursor_t cur_reg, cur_next;
    logic [31:0]      row_addr0_reg, row_addr0_next;
    logic [31:0]      row_addr1_reg, row_addr1_next;
    sgw_pkg::out_t    pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;
    sgw_pkg::out_t    out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic [12:0]   mul_y;
    logic [27:0]   mul_prod;
    logic [31:0]   row_sum;
    logic          visible;
    sgw_pkg::out_t cand;
    logic          out_free;
    logic          cur_final;
    logic          stall;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_base_reg    <= 32'd0;
            screen_width_reg  <= 13'd1024;
            screen_height_reg <= 13'd768;
            line_pitch_reg    <= 15'd4096;
            pixel_mode_reg    <= sgw_pkg::MODE_BGRA32;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sgw_pkg::REG_FRAME_BASE:    frame_base_reg    <= cfg_wdata;
                sgw_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wdata[12:0];
                sgw_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg_wdata[12:0];
                sgw_pkg::REG_LINE_PITCH:    line_pitch_reg    <= cfg_wdata[14:0];
                sgw_pkg::REG_PIXEL_MODE:    pixel_mode_reg    <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Shared multiplier: line start for the first, then the second sub-row.
    assign mul_y    = (state_reg == sgw_pkg::ST_ROW1) ? y0_reg + 13'd1 : y0_reg;
    assign mul_prod = 28'(mul_y) * 28'(line_pitch_reg);
    assign row_sum  = frame_base_reg + 32'(mul_prod);

    sgw_pixel_gen u_pixel_gen (
        .item          (item_reg),
        .y0            (y0_reg),
        .cur           (cur_reg),
        .pixel_mode    (pixel_mode_reg),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .row_addr0     (row_addr0_reg),
        .row_addr1     (row_addr1_reg),
        .visible       (visible),
        .cand          (cand)
    );

    // The last glyph column is one pixel wide, so its final candidate has sx low.
    assign out_free  = !out_valid_reg || m_ready;
    assign cur_final = (cur_reg.dx == 3'd7) && (cur_reg.sy == tall_reg);
    assign stall     = visible && pend_valid_reg && !out_free;
    assign s_ready   = (state_reg == sgw_pkg::ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_item    = out_reg;

    // Next state and datapath control.
    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        y0_next         = y0_reg;
        tall_next       = tall_reg;
        cur_next        = cur_reg;
        row_addr0_next  = row_addr0_reg;
        row_addr1_next  = row_addr1_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            sgw_pkg::ST_IDLE: begin
                if (s_valid) begin
                    item_next = s_item;
                    y0_next   = 13'(s_item.origin_y)
                                + 13'(sgw_pkg::row_offset(s_item.row_index));
                    tall_next = (s_item.row_index[1:0] != 2'd3);
                    cur_next  = '0;
                    if (pixel_mode_reg != sgw_pkg::MODE_NONE) begin
                        state_next = sgw_pkg::ST_ROW0;
                    end
                end
            end
            sgw_pkg::ST_ROW0: begin
                row_addr0_next = row_sum;
                state_next     = sgw_pkg::ST_ROW1;
            end
            sgw_pkg::ST_ROW1: begin
                row_addr1_next = row_sum;
                state_next     = sgw_pkg::ST_SWEEP;
            end
            sgw_pkg::ST_SWEEP: begin
                if (!stall) begin
                    // A visible pixel pushes the held write out and takes its place.
                    if (visible) begin
                        if (pend_valid_reg) begin
                            out_next       = pend_reg;
                            out_valid_next = 1'b1;
                        end
                        pend_next       = cand;
                        pend_valid_next = 1'b1;
                    end
                    // Step sub-column, then sub-row, then glyph column.
                    if (cur_final) begin
                        state_next = sgw_pkg::ST_FLUSH;
                    end else if (!cur_reg.dx[0] && !cur_reg.sx) begin
                        cur_next.sx = 1'b1;
                    end else if (tall_reg && !cur_reg.sy) begin
                        cur_next.sx = 1'b0;
                        cur_next.sy = 1'b1;
                    end else begin
                        cur_next.sx = 1'b0;
                        cur_next.sy = 1'b0;
                        cur_next.dx = cur_reg.dx + 3'd1;
                    end
                end
            end
            sgw_pkg::ST_FLUSH: begin
                // The held write is the final one of the item.
                if (!pend_valid_reg) begin
                    state_next = sgw_pkg::ST_IDLE;
                end else if (out_free) begin
                    out_next            = pend_reg;
                    out_next.last_write = 1'b1;
                    out_valid_next      = 1'b1;
                    pend_valid_next     = 1'b0;
                    state_next          = sgw_pkg::ST_IDLE;
                end
            end
            default: state_next = sgw_pkg::ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sgw_pkg::ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        y0_reg        <= y0_next;
        tall_reg      <= tall_next;
        cur_reg       <= cur_next;
        row_addr0_reg <= row_addr0_next;
        row_addr1_reg <= row_addr1_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
    end

endmodule

@@ sim/sgw_checker.sv @@
// Checker for the scaled glyph row pixel writer: predicts every framebuffer write and compares.
module sgw_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_wdata,
    input  logic          s_valid,
    input  logic          s_ready,
    input  sgw_pkg::in_t  s_item,
    input  logic          m_valid,
    input  logic          m_ready,
    input  sgw_pkg::out_t m_item,
    output int            fail_count,
    output int            pending,
    output int            writes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the configuration registers.
    logic [31:0] frame_base_q  = 32'd0;
    logic [12:0] width_q       = 13'd1024;
    logic [12:0] height_q      = 13'd768;
    logic [14:0] pitch_q       = 15'd4096;
    logic [1:0]  mode_q        = sgw_pkg::MODE_BGRA32;

    // Framebuffer writes still to be seen on the m_ channel, oldest first.
    sgw_pkg::out_t pixel_writes_q[$];
    sgw_pkg::out_t want;

    // Work out the writes that draw one scaled glyph row and queue them.
    function automatic void queue_row_writes(input sgw_pkg::in_t it);
        bit [31:0]     nbytes;
        bit [31:0]     lines;
        bit [31:0]     cols;
        bit [31:0]     y0;
        bit [31:0]     x0;
        bit [31:0]     x;
        bit [31:0]     y;
        bit [31:0]     data;
        logic [23:0]   colour;
        int unsigned   dx;
        int unsigned   sy;
        int unsigned   sx;
        int unsigned   n;
        sgw_pkg::out_t w;
        case (mode_q)
            sgw_pkg::MODE_BGRA32: nbytes = 4;
            sgw_pkg::MODE_BGR24:  nbytes = 3;
            sgw_pkg::MODE_RGB565: nbytes = 2;
            default:              return;
        endcase
        // Rows 3 and 7 of the glyph are one line high, the others two.
        lines = (it.row_index[1:0] == 2'd3) ? 1 : 2;
        y0 = 32'(it.origin_y) + (it.row_index[2] ? 7 : 0) + 32'(it.row_index[1:0]) * 2;
        n = 0;
        for (dx = 0; dx < 8; dx++) begin
            colour = it.glyph_row[7 - dx] ? it.fore_rgb : it.back_rgb;
            if (nbytes == 2)
                data = {16'h0, colour[23:19], colour[15:10], colour[7:3]};
            else
                data = {8'h0, colour};
            // Even columns are two pixels wide, odd ones a single pixel.
            cols = (dx & 1) ? 1 : 2;
            x0 = 32'(it.origin_x) + (dx >> 1) * 3 + (dx & 1) * 2;
            for (sy = 0; sy < lines; sy++) begin
                y = y0 + sy;
                for (sx = 0; sx < cols; sx++) begin
                    x = x0 + sx;
                    if (x < 32'(width_q) && y < 32'(height_q)) begin
                        w.byte_address = frame_base_q + y * 32'(pitch_q) + x * nbytes;
                        w.pixel_data   = data;
                        w.byte_count   = nbytes[2:0];
                        w.last_write   = 1'b0;
                        pixel_writes_q.push_back(w);
                        n++;
                    end
                end
            end
        end
        // The final visible pixel of the row carries the last flag.
        if (n > 0) begin
            w = pixel_writes_q.pop_back();
            w.last_write = 1'b1;
            pixel_writes_q.push_back(w);
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] got_val);
        if (got_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, got_val);
            fail_count++;
        end
    endfunction

    // Track register writes, queue predictions and compare each accepted write.
    always @(posedge aclk) begin
        if (!aresetn) begin
            frame_base_q = 32'd0;
            width_q      = 13'd1024;
            height_q     = 13'd768;
            pitch_q      = 15'd4096;
            mode_q       = sgw_pkg::MODE_BGRA32;
            pixel_writes_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    sgw_pkg::REG_FRAME_BASE:    frame_base_q = cfg_wdata;
                    sgw_pkg::REG_SCREEN_WIDTH:  width_q      = cfg_wdata[12:0];
                    sgw_pkg::REG_SCREEN_HEIGHT: height_q     = cfg_wdata[12:0];
                    sgw_pkg::REG_LINE_PITCH:    pitch_q      = cfg_wdata[14:0];
                    sgw_pkg::REG_PIXEL_MODE:    mode_q       = cfg_wdata[1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (pixel_writes_q.size() == 0) begin
                    $display("%0t: unexpected pixel write, expected none, actual addr %h data %h",
                             $time, m_item.byte_address, m_item.pixel_data);
                    fail_count++;
                end else begin
                    want = pixel_writes_q.pop_front();
                    check_field("byte_address", want.byte_address, m_item.byte_address);
                    check_field("pixel_data", want.pixel_data, m_item.pixel_data);
                    check_field("byte_count", 32'(want.byte_count), 32'(m_item.byte_count));
                    check_field("last_write", 32'(want.last_write), 32'(m_item.last_write));
                    writes_checked++;
                end
            end
            if (s_valid && s_ready)
                queue_row_writes(s_item);
        end
        pending = pixel_writes_q.size();
    end

endmodule

@@ sim/tb_scaled_glyph_row_pixel_writer.sv @@
// Testbench top of the scaled glyph row pixel writer: clock, reset, stimulus and verdict.
module tb_scaled_glyph_row_pixel_writer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         SETTLE_CYCLES = 40;
    localparam int         STALL_LIMIT   = 3000;
    localparam int         HOLD_AT_ROW   = 150;
    localparam int         HOLD_CYCLES   = 500;
    localparam int         ROWS_PER_SET  = 52;
    localparam int         RANDOM_SETS   = 9;
    localparam logic [2:0] REG_SPARE_LO  = sgw_pkg::REG_PIXEL_MODE + 3'd1;
    localparam logic [2:0] REG_SPARE_HI  = 3'd7;

    logic          aclk;
    logic          aresetn;
    logic          cfg_wr_en;
    logic [2:0]    cfg_index;
    logic [31:0]   cfg_wdata;
    logic          s_valid;
    logic          s_ready;
    sgw_pkg::in_t  s_item;
    logic          m_valid;
    logic          m_ready;
    sgw_pkg::out_t m_item;

    int fail_count;
    int pending;
    int writes_checked;
    int rows_sent     = 0;
    int settings_used = 0;
    int idle_cycles   = 0;
    int cur_w         = 1024;
    int cur_h         = 768;

    scaled_glyph_row_pixel_writer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    sgw_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_item         (s_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item         (m_item),
        .fail_count     (fail_count),
        .pending        (pending),
        .writes_checked (writes_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Give up when neither channel has moved an item for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired with %0d writes outstanding", $time, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic sgw_pkg::in_t make_row(input logic [7:0] glyph, input logic [2:0] row,
                                              input logic [11:0] ox, input logic [11:0] oy,
                                              input logic [23:0] fg, input logic [23:0] bg);
        sgw_pkg::in_t it;
        it.glyph_row = glyph;
        it.row_index = row;
        it.origin_x  = ox;
        it.origin_y  = oy;
        it.fore_rgb  = fg;
        it.back_rgb  = bg;
        return it;
    endfunction

    // Origin near the clip edge, well inside the screen, or anywhere at all.
    function automatic logic [11:0] pick_origin(input int limit, input int span, input int sel);
        int v;
        if (sel < 4)
            v = limit - int'($urandom_range(0, span));
        else if (sel < 7)
            v = (limit > span) ? int'($urandom_range(0, limit - span)) : 0;
        else
            v = int'($urandom_range(0, 4095));
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095 - int'($urandom_range(0, span));
        return 12'(v);
    endfunction

    // Offer one glyph row, hold it until taken, then, unless calm, sometimes idle for a random while.
    task automatic push_row(input sgw_pkg::in_t it, input bit calm);
        int gap;
        int r;
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        rows_sent++;
        @(negedge aclk);
        r = $urandom_range(0, 19);
        if (calm || r < 12)
            gap = 0;
        else if (r < 18)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Stop sending and wait for every write, then for any clipped tail to finish.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write all registers back to back, spare bits and an unused index included.
    task automatic program_regs(input logic [31:0] base, input int w, input int h,
                                input int pitch, input logic [1:0] mode);
        cfg_wr_en <= 1'b1;
        cfg_index <= sgw_pkg::REG_FRAME_BASE;
        cfg_wdata <= base;
        @(negedge aclk);
        cfg_index <= sgw_pkg::REG_SCREEN_WIDTH;
        cfg_wdata <= {19'($urandom()), 13'(w)};
        @(negedge aclk);
        cfg_index <= sgw_pkg::REG_SCREEN_HEIGHT;
        cfg_wdata <= {19'($urandom()), 13'(h)};
        @(negedge aclk);
        cfg_index <= sgw_pkg::REG_LINE_PITCH;
        cfg_wdata <= {17'($urandom()), 15'(pitch)};
        @(negedge aclk);
        cfg_index <= sgw_pkg::REG_PIXEL_MODE;
        cfg_wdata <= {30'($urandom()), mode};
        @(negedge aclk);
        cfg_index <= 3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI));
        cfg_wdata <= $urandom();
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_w = w;
        cur_h = h;
        settings_used++;
    endtask

    // Result side: bursts of ready and stalls, plus one long hold-off.
    initial begin : receiver
        int  stall;
        int  r;
        bit  held;
        held    = 1'b0;
        m_ready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge aclk);
            if (!held && rows_sent >= HOLD_AT_ROW) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            r = $urandom_range(0, 19);
            if (r < 3)
                stall = 0;
            else if (r < 15)
                stall = $urandom_range(1, 3);
            else if (r < 19)
                stall = $urandom_range(4, 10);
            else
                stall = $urandom_range(20, 60);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
        end
    end

    initial begin : stimulus
        sgw_pkg::in_t it;
        int           p;
        int           k;
        int           r;
        int           w;
        int           h;
        int           pitch;
        logic [31:0]  base;
        logic [1:0]   mode;
        bit           calm;

        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = sgw_pkg::REG_FRAME_BASE;
        cfg_wdata = 32'd0;
        s_valid   = 1'b0;
        s_item    = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Register defaults: every glyph row index, edge patterns and colour extremes.
        push_row(make_row(8'hFF, 3'd0, 12'd0, 12'd0, 24'hFFFFFF, 24'h000000), 1'b0);
        push_row(make_row(8'h00, 3'd1, 12'd0, 12'd0, 24'hFFFFFF, 24'h000000), 1'b0);
        push_row(make_row(8'hAA, 3'd2, 12'd0, 12'd0, 24'h000000, 24'hFFFFFF), 1'b0);
        push_row(make_row(8'h55, 3'd3, 12'd0, 12'd0, 24'h000000, 24'hFFFFFF), 1'b0);
        push_row(make_row(8'h81, 3'd4, 12'd1012, 12'd754, 24'h123456, 24'hABCDEF), 1'b0);
        push_row(make_row(8'h3C, 3'd5, 12'd1020, 12'd760, 24'hFF0000, 24'h00FF00), 1'b0);
        push_row(make_row(8'hC3, 3'd6, 12'd4095, 12'd4095, 24'h0000FF, 24'hFFFFFF), 1'b0);
        push_row(make_row(8'h18, 3'd7, 12'd100, 12'd200, 24'h123456, 24'hEDCBA9), 1'b0);

        // Largest screen and pitch near the top of the address space: clipping and wrap.
        wait_idle();
        program_regs(32'hFFFF_FF00, 4096, 4096, 16384, sgw_pkg::MODE_BGRA32);
        push_row(make_row(8'hFF, 3'd0, 12'd4095, 12'd4095, 24'hFFFFFF, 24'h000000), 1'b0);
        push_row(make_row(8'h96, 3'd7, 12'd4090, 12'd4080, 24'h0F0F0F, 24'hF0F0F0), 1'b0);

        // One pixel screen in 24-bit mode.
        wait_idle();
        program_regs(32'h0000_1000, 1, 1, 1, sgw_pkg::MODE_BGR24);
        push_row(make_row(8'h80, 3'd0, 12'd0, 12'd0, 24'hFFFFFF, 24'h000000), 1'b0);
        push_row(make_row(8'h80, 3'd1, 12'd0, 12'd0, 24'hFFFFFF, 24'h000000), 1'b0);

        // RGB565 packing on a small screen.
        wait_idle();
        program_regs(32'h8000_0000, 20, 20, 40, sgw_pkg::MODE_RGB565);
        push_row(make_row(8'hA5, 3'd0, 12'd0, 12'd0, 24'hF8FCF8, 24'h070307), 1'b0);
        push_row(make_row(8'h5A, 3'd3, 12'd10, 12'd10, 24'h84C3A5, 24'h5A3C21), 1'b0);
        push_row(make_row(8'hFF, 3'd6, 12'd15, 12'd8, 24'hFFFFFF, 24'h000000), 1'b0);

        // Unsupported mode writes nothing.
        wait_idle();
        program_regs(32'h0, 4096, 4096, 4096, sgw_pkg::MODE_NONE);
        push_row(make_row(8'hFF, 3'd0, 12'd0, 12'd0, 24'hFFFFFF, 24'h000000), 1'b0);
        push_row(make_row(8'h00, 3'd5, 12'd40, 12'd40, 24'hFFFFFF, 24'h000000), 1'b0);

        // Zero sized screen clips everything.
        wait_idle();
        program_regs(32'h0, 0, 0, 32767, sgw_pkg::MODE_BGRA32);
        push_row(make_row(8'hFF, 3'd2, 12'd0, 12'd0, 24'hFFFFFF, 24'h000000), 1'b0);

        // Random register settings, each followed by a batch of random glyph rows.
        for (p = 0; p < RANDOM_SETS; p++) begin
            wait_idle();
            base = (p == 0) ? 32'h0 : (p == 1) ? 32'hFFFF_FFFF : 32'($urandom());
            r = $urandom_range(0, 5);
            w = (r == 0) ? 1 : (r == 1) ? 4096 : int'($urandom_range(13, 4096));
            r = $urandom_range(0, 5);
            h = (r == 0) ? 1 : (r == 1) ? 4096 : int'($urandom_range(15, 4096));
            r = $urandom_range(0, 5);
            pitch = (r == 0) ? 1 : (r == 1) ? 16384 : int'($urandom_range(1, 16384));
            if ($urandom_range(0, 9) == 0)
                mode = sgw_pkg::MODE_NONE;
            else
                mode = 2'($urandom_range(sgw_pkg::MODE_BGRA32, sgw_pkg::MODE_RGB565));
            program_regs(base, w, h, pitch, mode);
            calm = (p % 3 == 2);
            for (k = 0; k < ROWS_PER_SET; k++) begin
                r = $urandom_range(0, 9);
                it.glyph_row = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom());
                it.row_index = 3'($urandom());
                it.origin_x  = pick_origin(cur_w, 12, $urandom_range(0, 9));
                it.origin_y  = pick_origin(cur_h, 14, $urandom_range(0, 9));
                it.fore_rgb  = 24'($urandom());
                it.back_rgb  = 24'($urandom());
                push_row(it, calm);
                // Once, let the block drain completely mid-batch.
                if (p == 3 && k == ROWS_PER_SET / 2)
                    wait_idle();
            end
        end

        wait_idle();
        $display("Summary: %0d glyph rows over %0d register settings, %0d pixel writes checked.",
                 rows_sent, settings_used + 1, writes_checked);
        $display("Summary: %0d mismatches found.", fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
sv/sgw_pkg.sv
sv/sgw_pixel_gen.sv
sv/scaled_glyph_row_pixel_writer.sv
sim/sgw_checker.sv
sim/tb_scaled_glyph_row_pixel_writer.sv
